>>> rtl/kpm_pkg.sv
// Shared types and constants for the k-means point move engine.
// No dependencies; used by kpm_div and kmeans_point_move_engine.
package kpm_pkg;

    localparam int KpmMaxClusters = 64;
    localparam int KpmMaxDims     = 64;
    localparam int KpmMaxPoints   = 65535;

    localparam int NumW   = 57;   // widest dividend: 56-bit product plus rounding
    localparam int DivW   = 17;   // divisor n+1 or n-1 of a 16-bit count
    localparam int IterW  = 6;

    localparam logic [39:0] SUM_MAX  = 40'hFF_FFFF_FFFF;
    localparam logic [46:0] COST_MAX = 47'h7FFF_FFFF_FFFF;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_INVAL = 2'd2;

    typedef enum logic [2:0] {
        OP_LOAD_COORD = 3'd0,
        OP_LOAD_COUNT = 3'd1,
        OP_EVAL_MOVE  = 3'd2,
        OP_APPLY_MOVE = 3'd3,
        OP_ADD_COST   = 3'd4,
        OP_CLEAR      = 3'd5
    } op_t;

    typedef struct packed {
        logic              start;
        logic [NumW-1:0]   numer;   // dividend, left aligned
        logic [IterW-1:0]  iters;   // quotient bits to produce
        logic [DivW-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [NumW-1:0]   quot;
    } div_res_t;

endpackage

>>> rtl/kpm_div.sv
// Shared iterative restoring divider, one quotient bit per cycle.
// Depends on kpm_pkg for the request and result structs.
module kpm_div
    import kpm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_res_t res
);

    logic [NumW-1:0]  q_reg, q_next;
    logic [DivW-1:0]  rem_reg, rem_next;
    logic [DivW-1:0]  d_reg, d_next;
    logic [IterW-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DivW:0]    trial;
    logic             ge;

    always_comb begin
        trial     = {rem_reg, q_reg[NumW-1]};
        ge        = trial >= {1'b0, d_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            q_next    = req.numer;
            rem_next  = '0;
            d_next    = req.divisor;
            cnt_next  = req.iters;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = {q_reg[NumW-2:0], ge};
            rem_next = ge ? DivW'(trial - {1'b0, d_reg}) : trial[DivW-1:0];
            cnt_next = cnt_reg - IterW'(1);
            if (cnt_reg == IterW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign res.busy = busy_reg;
    assign res.done = done_reg;
    assign res.quot = q_reg;

endmodule

>>> rtl/kmeans_point_move_engine.sv
// Top level of the k-means point move engine: sequencer, centroid and count memories.
// Depends on kpm_pkg and kpm_div.
//
// Use: requests arrive on the s_ stream, one point coordinate per request, with s_tlast on
// the final coordinate and the operation in s_tuser. Load requests write a centroid
// coordinate or a cluster count and give no result. Evaluate, apply and add-cost requests
// give one result on the last coordinate; clear-total gives one result at once.
// Results leave on the m_ stream through an output register, so a new request is taken
// while an earlier result still waits for m_tready.
// Configuration writes (dims_in_use, clusters_in_use) come on the cfg_ channel and are
// always accepted; issue them only while the engine is idle.
// The engine takes one request at a time. A distance coordinate does two count reads, then
// a read, square and accumulate per centroid; an apply coordinate runs one or two 33-bit
// divisions in the shared one-bit-per-cycle divider. A final evaluate adds one or two
// 57-bit divisions.
// Reset clears the sums, running total, flags and configuration (both 64); centroid and
// count memories hold nothing until written. A stalled receiver holds the result in place,
// and a following result waits in the sequencer until the output register frees.
module kmeans_point_move_engine
    import kpm_pkg::*;
#(
    parameter int MAX_CLUSTERS = KpmMaxClusters,
    parameter int MAX_DIMS     = KpmMaxDims,
    parameter int MAX_POINTS   = KpmMaxPoints
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // from_cluster[5:0], to_cluster[11:6], dim_index[17:12], coordinate[33:18],
    // count_value[49:34], zero pad
    input  logic [55:0]  s_tdata,
    input  logic         s_tlast,   // last_coord
    input  logic [2:0]   s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    // move_delta[47:0], point_distance[87:48], cost_total[134:88], zero pad
    output logic [135:0] m_tdata,
    output logic [1:0]   m_tuser,   // status
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [6:0]   cfg_data
);

    localparam int CIW = $clog2(MAX_CLUSTERS);
    localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int AW  = CIW + DIW;

    typedef enum logic [18:0] {
        S_IDLE    = 19'h00001,
        S_RDCF    = 19'h00002,
        S_RDCT    = 19'h00004,
        S_CHK     = 19'h00008,
        S_DS_RD   = 19'h00010,
        S_DS_MUL  = 19'h00020,
        S_DS_ACC  = 19'h00040,
        S_UP_RD   = 19'h00080,
        S_UP_MUL  = 19'h00100,
        S_UP_DIV  = 19'h00200,
        S_UP_WAIT = 19'h00400,
        S_END     = 19'h00800,
        S_FMUL    = 19'h01000,
        S_FDIV    = 19'h02000,
        S_FWAIT   = 19'h04000,
        S_CNT_T   = 19'h08000,
        S_CNT_F   = 19'h10000,
        S_COST    = 19'h20000,
        S_OUT     = 19'h40000
    } state_t;

    function automatic logic [CIW-1:0] cidx(input logic [5:0] c);
        logic [8:0] w;
        w = {3'b0, c};
        return w[CIW-1:0];
    endfunction

    function automatic logic [DIW-1:0] didx(input logic [5:0] d);
        logic [8:0] w;
        w = {3'b0, d};
        return w[DIW-1:0];
    endfunction

    // ---- registers ----
    state_t        state_reg, state_next;
    op_t           op_reg, op_next;
    logic [5:0]    from_reg, from_next, to_reg, to_next, dim_reg, dim_next;
    logic [15:0]   x_reg, x_next;
    logic          last_reg, last_next;
    logic [15:0]   nf_reg, nf_next, nt_reg, nt_next;
    logic          inv_reg, inv_next;
    logic          sel_reg, sel_next;     // second pass: from-side distance, to-side update, p2
    logic [31:0]   sq_reg, sq_next;
    logic signed [32:0] prod_reg, prod_next;
    logic [55:0]   fprod_reg, fprod_next;
    logic [39:0]   to_sum_reg, to_sum_next, from_sum_reg, from_sum_next;
    logic [46:0]   cost_reg, cost_next;
    logic          flag_reg, flag_next;
    logic [40:0]   p1_reg, p1_next, p2_reg, p2_next;
    logic [6:0]    dims_reg, dims_next, clusters_reg, clusters_next;
    logic          m_valid_reg, m_valid_next;
    logic [135:0]  m_data_reg, m_data_next;
    logic [1:0]    m_user_reg, m_user_next;

    // ---- memories ----
    logic [15:0]   cent_mem [1 << AW];
    logic [15:0]   cnt_mem  [1 << CIW];
    logic [15:0]   cent_rdata_reg, cnt_rdata_reg;
    logic          cent_we, cnt_we;
    logic [AW-1:0] cent_waddr, cent_raddr;
    logic [CIW-1:0] cnt_waddr, cnt_raddr;
    logic [15:0]   cent_wdata, cnt_wdata;

    div_req_t      div_req;
    div_res_t      div_res;

    kpm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .res     (div_res)
    );

    // ---- request fields ----
    logic [2:0]  in_op;
    logic [5:0]  in_from, in_to, in_dim;
    logic [15:0] in_x, in_cnt;
    logic        s_fire;

    assign in_op   = s_tuser;
    assign in_from = s_tdata[5:0];
    assign in_to   = s_tdata[11:6];
    assign in_dim  = s_tdata[17:12];
    assign in_x    = s_tdata[33:18];
    assign in_cnt  = s_tdata[49:34];
    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    function automatic logic cl_ok(input logic [5:0] c, input logic [6:0] lim);
        return ({3'b0, c} < {2'b0, lim}) && ({3'b0, c} < 9'(MAX_CLUSTERS));
    endfunction

    function automatic logic dm_ok(input logic [5:0] d, input logic [6:0] lim);
        return ({3'b0, d} < {2'b0, lim}) && ({3'b0, d} < 9'(MAX_DIMS));
    endfunction

    // ---- datapath helpers ----
    logic              move_ok, item_ok;
    logic [5:0]        cur_c;
    logic [15:0]       cur_n;
    logic signed [16:0] diff;
    logic signed [33:0] sq_full;
    logic [40:0]       acc_sum;
    logic signed [33:0] upd_val;
    logic [32:0]       upd_mag, upd_num, q33;
    logic [16:0]       d_to, d_from, upd_d, fin_d;
    logic [56:0]       fin_num;
    logic [47:0]       cost_sum;
    logic [15:0]       upd_res;
    logic              upd_sat;
    logic [47:0]       delta;

    always_comb begin
        d_to   = {1'b0, nt_reg} + 17'd1;
        d_from = {1'b0, nf_reg} - 17'd1;
        cur_c  = sel_reg ? from_reg : to_reg;
        cur_n  = sel_reg ? nt_reg : nf_reg;     // update pass: from first, then to
        // the counts check uses the fresh to-count straight from the memory
        move_ok = cl_ok(from_reg, clusters_reg) && cl_ok(to_reg, clusters_reg)
                  && (nf_reg != 16'd0)
                  && !(({8'b0, cnt_rdata_reg} >= 24'(MAX_POINTS))
                       || (cnt_rdata_reg == 16'hFFFF));
        item_ok = (op_reg == OP_ADD_COST) ? cl_ok(to_reg, clusters_reg) : move_ok;

        diff    = $signed({x_reg[15], x_reg}) - $signed({cent_rdata_reg[15], cent_rdata_reg});
        sq_full = diff * diff;
        acc_sum = {1'b0, sel_reg ? from_sum_reg : to_sum_reg} + {9'b0, sq_reg};

        upd_val = sel_reg ? ({prod_reg[32], prod_reg} + {{18{x_reg[15]}}, x_reg})
                          : ({prod_reg[32], prod_reg} - {{18{x_reg[15]}}, x_reg});
        upd_mag = upd_val[33] ? 33'(-upd_val) : upd_val[32:0];
        upd_d   = sel_reg ? d_to : d_from;
        upd_num = upd_mag + {17'b0, upd_d[16:1]};

        fin_d   = sel_reg ? d_from : d_to;
        fin_num = {1'b0, fprod_reg} + {41'b0, fin_d[16:1]};

        q33     = div_res.quot[32:0];
        upd_sat = 1'b0;
        if (upd_val[33]) begin
            if (q33 > 33'd32768) begin
                upd_res = 16'h8000;
                upd_sat = 1'b1;
            end else begin
                upd_res = 16'(-q33);
            end
        end else if (q33 > 33'd32767) begin
            upd_res = 16'h7FFF;
            upd_sat = 1'b1;
        end else begin
            upd_res = q33[15:0];
        end

        cost_sum = {1'b0, cost_reg} + {8'b0, to_sum_reg};
        // p1 and p2 stay below 2^41, so the difference always fits
        delta    = {7'b0, p1_reg} - {7'b0, p2_reg};
    end

    // ---- sequencer ----
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        from_next     = from_reg;
        to_next       = to_reg;
        dim_next      = dim_reg;
        x_next        = x_reg;
        last_next     = last_reg;
        nf_next       = nf_reg;
        nt_next       = nt_reg;
        inv_next      = inv_reg;
        sel_next      = sel_reg;
        sq_next       = sq_reg;
        prod_next     = prod_reg;
        fprod_next    = fprod_reg;
        to_sum_next   = to_sum_reg;
        from_sum_next = from_sum_reg;
        cost_next     = cost_reg;
        flag_next     = flag_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        dims_next     = dims_reg;
        clusters_next = clusters_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;

        cent_we    = 1'b0;
        cent_waddr = {cidx(to_reg), didx(dim_reg)};
        cent_wdata = upd_res;
        cent_raddr = {cidx(cur_c), didx(dim_reg)};
        cnt_we     = 1'b0;
        cnt_waddr  = cidx(to_reg);
        cnt_wdata  = nt_reg + 16'd1;
        cnt_raddr  = cidx(from_reg);

        div_req.start   = 1'b0;
        div_req.numer   = {upd_num, 24'b0};
        div_req.iters   = IterW'(33);
        div_req.divisor = upd_d;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready) begin
            if (cfg_index) begin
                clusters_next = cfg_data;
            end else begin
                dims_next = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    op_next   = op_t'(in_op);
                    from_next = in_from;
                    to_next   = in_to;
                    dim_next  = in_dim;
                    x_next    = in_x;
                    last_next = s_tlast;
                    case (in_op)
                        OP_LOAD_COORD: begin
                            cent_we    = cl_ok(in_to, clusters_reg) && dm_ok(in_dim, dims_reg);
                            cent_waddr = {cidx(in_to), didx(in_dim)};
                            cent_wdata = in_x;
                        end
                        OP_LOAD_COUNT: begin
                            cnt_we    = cl_ok(in_to, clusters_reg);
                            cnt_waddr = cidx(in_to);
                            cnt_wdata = in_cnt;
                        end
                        OP_EVAL_MOVE, OP_APPLY_MOVE, OP_ADD_COST: begin
                            state_next = S_RDCF;
                        end
                        OP_CLEAR: begin
                            state_next = S_OUT;
                        end
                        default: begin
                            // unused codes: drop the request
                        end
                    endcase
                end
            end
            S_RDCF: begin
                cnt_raddr  = cidx(from_reg);
                state_next = S_RDCT;
            end
            S_RDCT: begin
                cnt_raddr  = cidx(to_reg);
                nf_next    = cnt_rdata_reg;
                state_next = S_CHK;
            end
            S_CHK: begin
                nt_next  = cnt_rdata_reg;
                sel_next = 1'b0;
                if (!item_ok) begin
                    inv_next   = 1'b1;
                    state_next = S_END;
                end else if (!dm_ok(dim_reg, dims_reg)) begin
                    state_next = S_END;
                end else if (op_reg == OP_APPLY_MOVE) begin
                    sel_next   = 1'b0;
                    state_next = S_UP_RD;
                end else begin
                    state_next = S_DS_RD;
                end
            end
            S_DS_RD: begin
                // sel_reg low: to-centroid, high: from-centroid
                cent_raddr = {cidx(sel_reg ? from_reg : to_reg), didx(dim_reg)};
                state_next = S_DS_MUL;
            end
            S_DS_MUL: begin
                sq_next    = sq_full[31:0];
                state_next = S_DS_ACC;
            end
            S_DS_ACC: begin
                if (acc_sum > {1'b0, SUM_MAX}) begin
                    flag_next = 1'b1;
                end
                if (sel_reg) begin
                    from_sum_next = (acc_sum > {1'b0, SUM_MAX}) ? SUM_MAX : acc_sum[39:0];
                end else begin
                    to_sum_next = (acc_sum > {1'b0, SUM_MAX}) ? SUM_MAX : acc_sum[39:0];
                end
                if ((op_reg == OP_EVAL_MOVE) && !sel_reg) begin
                    sel_next   = 1'b1;
                    state_next = S_DS_RD;
                end else begin
                    state_next = S_END;
                end
            end
            S_UP_RD: begin
                cent_raddr = {cidx(sel_reg ? to_reg : from_reg), didx(dim_reg)};
                state_next = S_UP_MUL;
            end
            S_UP_MUL: begin
                if (!sel_reg && (nf_reg <= 16'd1)) begin
                    // a source left with one point collapses to zero
                    cent_we    = 1'b1;
                    cent_waddr = {cidx(from_reg), didx(dim_reg)};
                    cent_wdata = 16'h0000;
                    sel_next   = 1'b1;
                    state_next = S_UP_RD;
                end else begin
                    prod_next  = $signed({1'b0, cur_n}) * $signed(cent_rdata_reg);
                    state_next = S_UP_DIV;
                end
            end
            S_UP_DIV: begin
                div_req.start = 1'b1;
                state_next    = S_UP_WAIT;
            end
            S_UP_WAIT: begin
                if (div_res.done) begin
                    cent_we    = 1'b1;
                    cent_waddr = {cidx(sel_reg ? to_reg : from_reg), didx(dim_reg)};
                    if (upd_sat) begin
                        flag_next = 1'b1;
                    end
                    if (sel_reg) begin
                        state_next = S_END;
                    end else begin
                        sel_next   = 1'b1;
                        state_next = S_UP_RD;
                    end
                end
            end
            S_END: begin
                sel_next = 1'b0;
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (inv_reg) begin
                    state_next = S_OUT;
                end else if (op_reg == OP_EVAL_MOVE) begin
                    state_next = S_FMUL;
                end else if (op_reg == OP_APPLY_MOVE) begin
                    state_next = S_CNT_T;
                end else begin
                    state_next = S_COST;
                end
            end
            S_FMUL: begin
                fprod_next = sel_reg ? (nf_reg * from_sum_reg) : (nt_reg * to_sum_reg);
                state_next = S_FDIV;
            end
            S_FDIV: begin
                div_req.start   = 1'b1;
                div_req.numer   = fin_num;
                div_req.iters   = IterW'(NumW);
                div_req.divisor = fin_d;
                state_next      = S_FWAIT;
            end
            S_FWAIT: begin
                if (div_res.done) begin
                    if (sel_reg) begin
                        p2_next    = div_res.quot[40:0];
                        state_next = S_OUT;
                    end else begin
                        p1_next = div_res.quot[40:0];
                        if (nf_reg > 16'd1) begin
                            sel_next   = 1'b1;
                            state_next = S_FMUL;
                        end else begin
                            p2_next    = '0;
                            state_next = S_OUT;
                        end
                    end
                end
            end
            S_CNT_T: begin
                // same source and destination: counts end unchanged, skip both writes
                cnt_we     = (from_reg != to_reg);
                cnt_waddr  = cidx(to_reg);
                cnt_wdata  = nt_reg + 16'd1;
                state_next = S_CNT_F;
            end
            S_CNT_F: begin
                cnt_we     = (from_reg != to_reg);
                cnt_waddr  = cidx(from_reg);
                cnt_wdata  = nf_reg - 16'd1;
                state_next = S_OUT;
            end
            S_COST: begin
                if (cost_sum > {1'b0, COST_MAX}) begin
                    cost_next = COST_MAX;
                    flag_next = 1'b1;
                end else begin
                    cost_next = cost_sum[46:0];
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    if (op_reg == OP_CLEAR) begin
                        m_data_next = '0;
                        m_user_next = ST_OK;
                        cost_next   = '0;
                    end else if (inv_reg) begin
                        m_data_next = {1'b0, cost_reg, 40'b0, 48'b0};
                        m_user_next = ST_INVAL;
                    end else begin
                        m_user_next = flag_reg ? ST_SAT : ST_OK;
                        case (op_reg)
                            OP_EVAL_MOVE:
                                m_data_next = {1'b0, cost_reg, to_sum_reg, delta};
                            OP_ADD_COST:
                                m_data_next = {1'b0, cost_reg, to_sum_reg, 48'b0};
                            default:
                                m_data_next = {1'b0, cost_reg, 40'b0, 48'b0};
                        endcase
                    end
                    to_sum_next   = '0;
                    from_sum_next = '0;
                    flag_next     = 1'b0;
                    inv_next      = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            inv_reg      <= 1'b0;
            flag_reg     <= 1'b0;
            to_sum_reg   <= '0;
            from_sum_reg <= '0;
            cost_reg     <= '0;
            dims_reg     <= 7'd64;
            clusters_reg <= 7'd64;
            m_valid_reg  <= 1'b0;
            sel_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            inv_reg      <= inv_next;
            flag_reg     <= flag_next;
            to_sum_reg   <= to_sum_next;
            from_sum_reg <= from_sum_next;
            cost_reg     <= cost_next;
            dims_reg     <= dims_next;
            clusters_reg <= clusters_next;
            m_valid_reg  <= m_valid_next;
            sel_reg      <= sel_next;
        end
        op_reg     <= op_next;
        from_reg   <= from_next;
        to_reg     <= to_next;
        dim_reg    <= dim_next;
        x_reg      <= x_next;
        last_reg   <= last_next;
        nf_reg     <= nf_next;
        nt_reg     <= nt_next;
        sq_reg     <= sq_next;
        prod_reg   <= prod_next;
        fprod_reg  <= fprod_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // centroid memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cent_we) begin
            cent_mem[cent_waddr] <= cent_wdata;
        end
        cent_rdata_reg <= cent_mem[cent_raddr];
    end

    // count memory
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata_reg <= cnt_mem[cnt_raddr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // ---- assertions ----
    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_res.busy)
        else $error("divider busy while accepting requests");

    a_div_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> $past(div_res.busy))
        else $error("divider done without a running division");

    a_out_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) && !m_valid_reg |=> m_valid_reg)
        else $error("result not loaded into free output register");

endmodule
